[hw/rtl/mexp_pkg.sv]
package mexp_pkg;

  // Working width of exponent, modulus and message; the ports stay at FIELD_W.
  localparam int WIDTH     = 64;
  localparam int FIELD_W   = 64;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

  localparam logic [WIDTH-1:0] EXPONENT_RESET = WIDTH'(1);
  localparam logic [WIDTH-1:0] MODULUS_RESET  = WIDTH'(2);

  typedef logic [WIDTH-1:0] word_t;

  // Status of the serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

[hw/rtl/mexp_msg_if.sv]
interface mexp_msg_if import mexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink (input valid, input message, output ready);
endinterface

[hw/rtl/mexp_res_if.sv]
interface mexp_res_if import mexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

[hw/rtl/modular_exponentiation.sv]
// Raises each message word to the configured exponent modulo the configured modulus, using
// right-to-left square-and-multiply over one bit-serial modular multiplier that consumes one
// multiplier bit per cycle. An item first has its message reduced, then for each exponent bit
// up to its highest set bit the bit is looked at, a multiply is done where the bit is set and
// a squaring follows (the final squaring is skipped). A modulus of zero returns 0 without a
// multiply; an exponent of zero still reduces the message. One word is worked on at a time;
// the next is taken once the result sits in the output register. Write exponent and modulus
// only while the block is idle.
module modular_exponentiation import mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  mexp_msg_if.sink             msg,
  mexp_res_if.source           res
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_BIT  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t   state;
  state_t   state_next;
  word_t    exponent;
  word_t    modulus;
  word_t    e_q;
  word_t    base;
  word_t    acc;
  word_t    res_data;
  logic     res_valid;
  logic     accept;
  logic     load_out;
  logic     mm_start;
  word_t    mm_a;
  word_t    mm_b;
  word_t    mm_product;
  mm_stat_t mm_stat;

  assign msg.ready = (state == S_IDLE);
  assign accept    = msg.valid && msg.ready;
  assign load_out  = (state == S_DONE) && (!res_valid || res.ready);

  always_comb begin
    state_next = state;
    mm_start   = 1'b0;
    mm_a       = base;
    mm_b       = base;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (modulus == '0) begin
            state_next = S_DONE;
          end else begin
            // reduce the message as 1 * message mod m
            mm_start   = 1'b1;
            mm_a       = WIDTH'(1);
            mm_b       = msg.message[WIDTH-1:0];
            state_next = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_stat.done) state_next = S_BIT;
      end
      S_BIT: begin
        if (e_q == '0) begin
          state_next = S_DONE;
        end else if (e_q[0]) begin
          mm_start   = 1'b1;
          mm_a       = acc;
          state_next = S_MUL;
        end else begin
          mm_start   = 1'b1;
          state_next = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          // drop the last squaring, nothing uses it
          if (e_q[WIDTH-1:1] == '0) begin
            state_next = S_DONE;
          end else begin
            mm_start   = 1'b1;
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_stat.done) state_next = S_BIT;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  mexp_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .m       (modulus),
    .product (mm_product),
    .stat    (mm_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      exponent  <= EXPONENT_RESET;
      modulus   <= MODULUS_RESET;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_EXPONENT: exponent <= cfg_data[WIDTH-1:0];
          REG_MODULUS:  modulus  <= cfg_data[WIDTH-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_q <= exponent;
      acc <= '0;
    end
    if (state == S_RED && mm_stat.done) begin
      base <= mm_product;
      acc  <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
    end
    if (state == S_MUL && mm_stat.done) begin
      acc <= mm_product;
    end
    if (state == S_SQR && mm_stat.done) begin
      base <= mm_product;
      e_q  <= e_q >> 1;
    end
    if (load_out) begin
      res_data <= acc;
    end
  end

  assign res.valid        = res_valid;
  assign res.power_result = FIELD_W'(res_data);

`ifndef SYNTH
  a_done_awaited: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == S_RED || state == S_MUL || state == S_SQR))
    else $error("multiplier finished with no product awaited");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  a_operands_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_BIT) |-> (base < modulus && acc < modulus))
    else $error("base or accumulator not reduced below modulus");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside the done state");
`endif

endmodule

[hw/rtl/mexp_modmul.sv]
module mexp_modmul import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  word_t    a,
  input  word_t    b,
  input  word_t    m,
  output word_t    product,
  output mm_stat_t stat
);

  word_t            a_q;
  word_t            b_q;
  word_t            m_q;
  word_t            r;
  word_t            r_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] d1;
  logic [WIDTH+1:0] d2;

  // One multiplier bit a cycle, top bit first: r = 2r + bit*a, then fold below m.
  // With r < m and a <= m the sum stays under 3m.
  always_comb begin
    t  = {1'b0, r, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
    d1 = t - {2'b00, m_q};
    d2 = t - {1'b0, m_q, 1'b0};
    if (t >= {1'b0, m_q, 1'b0}) begin
      r_next = d2[WIDTH-1:0];
    end else if (t >= {2'b00, m_q}) begin
      r_next = d1[WIDTH-1:0];
    end else begin
      r_next = t[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      m_q <= m;
      r   <= '0;
      cnt <= '0;
    end else if (busy) begin
      r   <= r_next;
      b_q <= {b_q[WIDTH-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign product = r;
  assign stat    = '{busy: busy, done: done};

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb import mexp_pkg::*; ();

  localparam int GAP_MAX      = 13;
  localparam int RANDOM_WORDS = 100;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int N_VECTORS    = 23;

  // Indexes past the register list; writes there must leave the keys alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  localparam word_t ALL_ONES = '1;

  typedef struct packed {
    logic  load_keys;
    logic  spare_writes;
    word_t exponent;
    word_t modulus;
    word_t message;
    logic  typed;
    word_t power;
  } vector_t;

  vector_t vectors [N_VECTORS] = '{
    // keys from reset: exponent 1, modulus 2
    '{1'b0, 1'b0, 64'd0, 64'd0, 64'd5, 1'b1, 64'd1},
    '{1'b0, 1'b0, 64'd0, 64'd0, ALL_ONES, 1'b1, 64'd1},
    '{1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 1'b1, 64'd0},
    // zero exponent gives one, or zero under a modulus of one
    '{1'b1, 1'b0, 64'd0, 64'd1000, 64'd12345, 1'b1, 64'd1},
    '{1'b0, 1'b0, 64'd0, 64'd0, ALL_ONES, 1'b1, 64'd1},
    '{1'b1, 1'b0, 64'd0, 64'd1, 64'd7, 1'b1, 64'd0},
    '{1'b1, 1'b0, ALL_ONES, 64'd1, ALL_ONES, 1'b1, 64'd0},
    // modulus zero returns zero
    '{1'b1, 1'b0, 64'd5, 64'd0, 64'd3, 1'b1, 64'd0},
    '{1'b1, 1'b0, 64'd0, 64'd0, 64'd9, 1'b1, 64'd0},
    // textbook key pair, encrypt then decrypt
    '{1'b1, 1'b0, 64'd17, 64'd3233, 64'd65, 1'b1, 64'd2790},
    '{1'b1, 1'b1, 64'd2753, 64'd3233, 64'd2790, 1'b1, 64'd65},
    '{1'b1, 1'b0, 64'd1, ALL_ONES, ALL_ONES, 1'b1, 64'd0},
    '{1'b0, 1'b0, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE},
    '{1'b1, 1'b0, 64'd2, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'd1},
    '{1'b1, 1'b0, ALL_ONES, ALL_ONES, 64'd0, 1'b1, 64'd0},
    '{1'b0, 1'b0, 64'd0, 64'd0, 64'd1, 1'b1, 64'd1},
    // Fermat: largest 64-bit prime, then the Mersenne prime 2^61-1
    '{1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFC4, 64'hFFFF_FFFF_FFFF_FFC5,
      64'hDEAD_BEEF_0123_4567, 1'b1, 64'd1},
    '{1'b1, 1'b0, 64'h1FFF_FFFF_FFFF_FFFE, 64'h1FFF_FFFF_FFFF_FFFF,
      ALL_ONES, 1'b1, 64'd1},
    '{1'b1, 1'b0, ALL_ONES, 64'h8000_0000_0000_0001, 64'h1234_5678_9ABC_DEF0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'h8000_0000_0000_0000, 64'd1_000_000_007, 64'd2, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'd3, ALL_ONES, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAB,
      64'h5555_5555_5555_5555, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'd65537, 64'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0001, 1'b0, 64'd0}
  };

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data  = '0;

  mexp_msg_if msg_ch ();
  mexp_res_if res_ch ();

  modular_exponentiation uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg       (msg_ch),
    .res       (res_ch)
  );

  word_t key_exponent = EXPONENT_RESET;
  word_t key_modulus  = MODULUS_RESET;
  word_t pending_powers [$];
  int    mismatches   = 0;
  int    words_sent   = 0;
  int    results_seen = 0;
  int    key_loads    = 0;
  bit    no_idle      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  // Random value of exactly n significant bits.
  function automatic word_t rand_bits(input int n);
    word_t v;
    v = rand64();
    if (n < WIDTH) v = v >> (WIDTH - n);
    v[n-1] = 1'b1;
    return v;
  endfunction

  function automatic word_t modexp_word(input word_t base, input word_t expo,
                                        input word_t modu);
    logic [2*WIDTH-1:0] wide_mod;
    logic [2*WIDTH-1:0] wide;
    word_t              acc;
    word_t              sq;
    int                 i;
    if (modu == '0) return '0;
    wide_mod = (2*WIDTH)'(modu);
    acc = (modu == word_t'(1)) ? '0 : word_t'(1);
    sq = base % modu;
    for (i = 0; i < WIDTH; i++) begin
      if (expo[i]) begin
        wide = (2*WIDTH)'(acc) * (2*WIDTH)'(sq);
        acc = word_t'(wide % wide_mod);
      end
      wide = (2*WIDTH)'(sq) * (2*WIDTH)'(sq);
      sq = word_t'(wide % wide_mod);
    end
    return acc;
  endfunction

  function automatic word_t pick_message(input word_t modu);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      2: return modu;
      3: return modu - 1;
      4: return modu + 1;
      5: return word_t'($urandom_range(0, 255));
      default: return rand64();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatches++;
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Drop valid, then hold until every word sent has come back.
  task automatic wait_idle();
    @(negedge clk);
    msg_ch.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_EXPONENT: key_exponent = value;
      REG_MODULUS:  key_modulus  = value;
      default: ;
    endcase
  endtask

  task automatic load_keys(input word_t expo, input word_t modu, input bit spare);
    wait_idle();
    write_reg(REG_EXPONENT, expo);
    write_reg(REG_MODULUS, modu);
    if (spare) begin
      write_reg(REG_SPARE_LO, rand64());
      write_reg(REG_SPARE_HI, rand64());
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    key_loads++;
  endtask

  task automatic send_word(input word_t word, input bit typed, input word_t power);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk);
    repeat (gap) begin
      msg_ch.valid   <= 1'b0;
      msg_ch.message <= rand64();
      @(negedge clk);
    end
    msg_ch.valid   <= 1'b1;
    msg_ch.message <= word;
    do @(posedge clk); while (msg_ch.ready !== 1'b1);
    pending_powers.push_back(typed ? power : modexp_word(word, key_exponent, key_modulus));
    words_sent++;
  endtask

  initial begin : result_sink
    int    stall;
    word_t want;
    res_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clk);
      repeat (stall) begin
        res_ch.ready <= 1'b0;
        @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      results_seen++;
      if (pending_powers.size() == 0) begin
        report_mismatch("result with no word pending", res_ch.power_result, '0);
      end else begin
        want = pending_powers.pop_front();
        if (res_ch.power_result !== want)
          report_mismatch("power_result", res_ch.power_result, want);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending_powers.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int    i;
    int    burst;
    int    random_sent;
    word_t expo;
    word_t modu;
    msg_ch.valid   = 1'b0;
    msg_ch.message = '0;
    random_sent    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_VECTORS; i++) begin
      if (vectors[i].load_keys)
        load_keys(vectors[i].exponent, vectors[i].modulus, vectors[i].spare_writes);
      send_word(vectors[i].message, vectors[i].typed, vectors[i].power);
    end

    // Keep most exponents short; a full-width one makes the slowest words.
    while (random_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       expo = '0;
        1:       expo = ALL_ONES;
        2, 3:    expo = rand_bits(WIDTH);
        default: expo = rand_bits($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 11))
        0:       modu = word_t'(1);
        1:       modu = ALL_ONES;
        2:       modu = word_t'(2);
        3, 4:    modu = rand_bits($urandom_range(2, 16));
        5, 6:    modu = rand_bits(WIDTH);
        default: modu = rand_bits($urandom_range(2, WIDTH));
      endcase
      load_keys(expo, modu, $urandom_range(0, 3) == 0);
      no_idle = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(6, 14);
      for (i = 0; i < burst && random_sent < RANDOM_WORDS; i++) begin
        send_word(pick_message(modu), 1'b0, '0);
        random_sent++;
      end
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d from the directed table) across %0d key loads, %0d results.",
             words_sent, N_VECTORS, key_loads, results_seen);
    $display("Keys spanned zero, one and two moduli up to full width; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_msg_if.sv
hw/rtl/mexp_res_if.sv
hw/rtl/mexp_modmul.sv
hw/rtl/modular_exponentiation.sv
dv/tb.sv
